>>> design/ring_buffer_deque_macros.svh
// ----------------------------------------------------------------------------
// ring_buffer_deque_macros.svh
// Assertion macros used by the deque top level.
// ----------------------------------------------------------------------------
`ifndef RING_BUFFER_DEQUE_MACROS_SVH
`define RING_BUFFER_DEQUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RBD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RBD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/rbd_pkg.sv
// ----------------------------------------------------------------------------
// rbd_pkg
// Types and constants for the ring buffer deque.
// ----------------------------------------------------------------------------
`default_nettype none

package rbd_pkg;

    localparam int DEPTH   = 16;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int SW      = AW + 1;
    localparam int DATA_W  = 32;
    localparam int FILL_W  = 5;
    localparam int STAT_W  = 2;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_CLEAR      = 3'd4
    } rbd_op_t;

    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]               op;
        logic signed [DATA_W-1:0] value;
    } rbd_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [STAT_W-1:0]        status;
        logic                     now_empty;
        logic                     now_full;
        logic [FILL_W-1:0]        fill_count;
    } rbd_out_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_RESP = 2'd2
    } rbd_state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } rbd_cmd_t;

endpackage

`default_nettype wire

>>> design/rbd_ctrl.sv
// ----------------------------------------------------------------------------
// rbd_ctrl
// Sequencer: accept one transaction, execute it, present the result.
// ----------------------------------------------------------------------------
`default_nettype none

module rbd_ctrl
    import rbd_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  wire logic     m_ready,
    output rbd_cmd_t      cmd
);

    rbd_state_t state_reg;
    rbd_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_RESP;
            end
            S_RESP: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        m_valid  = 1'b0;
        cmd.load = 1'b0;
        cmd.exec = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            S_EXEC: begin
                cmd.exec = 1'b1;
            end
            S_RESP: begin
                m_valid = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/rbd_datapath.sv
// ----------------------------------------------------------------------------
// rbd_datapath
// Ring store, head pointer, element count and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rbd_datapath
    import rbd_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire rbd_cmd_t cmd,
    input  wire rbd_in_t  s_item,
    output rbd_out_t      m_item
);

    logic [DATA_W-1:0] mem [DEPTH];

    logic [2:0]        op_reg;
    logic [DATA_W-1:0] value_reg;
    logic [AW-1:0]     head_reg;
    logic [AW-1:0]     head_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [DATA_W-1:0] rd_data_reg;
    logic              pop_ok_reg;
    logic              pop_ok_next;
    logic [STAT_W-1:0] status_reg;
    logic [STAT_W-1:0] status_next;

    logic              is_empty;
    logic              is_full;
    logic [AW-1:0]     head_dec;
    logic [AW-1:0]     head_inc;
    logic [CW-1:0]     offset;
    logic [SW-1:0]     slot_sum;
    logic [AW-1:0]     slot_tail;
    logic [AW-1:0]     addr;
    logic              wr_en;

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CW'(DEPTH));
    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);

    // Tail slot: (head + offset) wrapped once, offset is count or count-1
    assign offset    = (op_reg == OP_POP_BACK) ? count_reg - CW'(1) : count_reg;
    assign slot_sum  = SW'(head_reg) + SW'(offset);
    assign slot_tail = (slot_sum >= SW'(DEPTH)) ? AW'(slot_sum - SW'(DEPTH))
                                                : AW'(slot_sum);

    always_comb begin
        head_next   = head_reg;
        count_next  = count_reg;
        status_next = STAT_DONE;
        pop_ok_next = 1'b0;
        wr_en       = 1'b0;
        addr        = head_reg;
        case (op_reg)
            OP_PUSH_FRONT: begin
                addr = head_dec;
                if (is_full) begin
                    status_next = STAT_FULL;
                end else begin
                    wr_en      = 1'b1;
                    head_next  = head_dec;
                    count_next = count_reg + CW'(1);
                end
            end
            OP_PUSH_BACK: begin
                addr = slot_tail;
                if (is_full) begin
                    status_next = STAT_FULL;
                end else begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            OP_POP_FRONT: begin
                addr = head_reg;
                if (is_empty) begin
                    status_next = STAT_EMPTY;
                end else begin
                    pop_ok_next = 1'b1;
                    head_next   = head_inc;
                    count_next  = count_reg - CW'(1);
                end
            end
            OP_POP_BACK: begin
                addr = slot_tail;
                if (is_empty) begin
                    status_next = STAT_EMPTY;
                end else begin
                    pop_ok_next = 1'b1;
                    count_next  = count_reg - CW'(1);
                end
            end
            OP_CLEAR: begin
                head_next  = '0;
                count_next = '0;
            end
            default: begin
                status_next = STAT_DONE;
            end
        endcase
    end

    // Store: at most one write, and one registered read, per executed transaction
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            if (wr_en) begin
                mem[addr] <= value_reg;
            end
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= s_item.op;
            value_reg <= s_item.value;
        end
        if (cmd.exec) begin
            pop_ok_reg <= pop_ok_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else if (cmd.exec) begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    assign m_item.data       = pop_ok_reg ? rd_data_reg : '0;
    assign m_item.status     = status_reg;
    assign m_item.now_empty  = is_empty;
    assign m_item.now_full   = is_full;
    assign m_item.fill_count = FILL_W'(count_reg);

endmodule

`default_nettype wire

>>> design/ring_buffer_deque.sv
// ----------------------------------------------------------------------------
// ring_buffer_deque
// Double-ended queue of 32-bit words in a ring store with head and count.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_item: op, value
//  m_      | out       | m_valid / m_ready  | m_item: data, status, flags, fill
//
//  One transaction at a time: accept, execute, present; a new transaction
//  is taken only after the result is. The single ring store port does an
//  optional write and one registered read in the execute state.
//  Reset (aresetn low, synchronous) zeroes head and count; store contents
//  are not cleared and are never returned before written.
//  A stalled result holds the block; s_ready stays low until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_buffer_deque
    import rbd_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire rbd_in_t s_item,
    output logic         m_valid,
    input  wire logic    m_ready,
    output rbd_out_t     m_item
);

`include "ring_buffer_deque_macros.svh"

    rbd_cmd_t cmd;

    // Sequencer: hold the input side while a transaction is in flight
    rbd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Datapath: advance head and count, write or read the ring store
    rbd_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_item  (s_item),
        .m_item  (m_item)
    );

    // Never take a new transaction while a result is pending
    `RBD_ASSERT_NOW(a_one_in_flight, aclk, aresetn, m_valid, !s_ready,
        "input accepted while a result is pending")

    // An accepted transaction blocks the input in the following cycle
    `RBD_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready,
        "input still ready after accept")

    // Rejected operations carry zero data
    `RBD_ASSERT_NOW(a_reject_zero, aclk, aresetn,
        m_valid && (m_item.status != STAT_DONE), m_item.data == '0,
        "rejected operation returned nonzero data")

    // Empty flag agrees with the fill count
    `RBD_ASSERT_NOW(a_empty_flag, aclk, aresetn, m_valid,
        m_item.now_empty == (m_item.fill_count == '0),
        "empty flag disagrees with fill count")

endmodule

`default_nettype wire

>>> bench/deque_checker.sv
// ----------------------------------------------------------------------------
// deque_checker
// Watches both channels of the ring buffer deque. It keeps its own model of
// head, fill and ring contents, and predicts one result per accepted
// transaction. Each returned result is compared field by field with the
// oldest prediction.
// ----------------------------------------------------------------------------
module deque_checker
    import rbd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  rbd_in_t  s_item,
    input  logic     m_valid,
    input  logic     m_ready,
    input  rbd_out_t m_item,
    output int       mismatches,
    output int       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [AW-1:0]     head_slot;
    logic [CW-1:0]     used;
    logic [DATA_W-1:0] ring [DEPTH];
    rbd_out_t          predicted_results[$];

    function automatic logic [AW-1:0] slot_at(input int offset);
        return AW'((int'(head_slot) + offset) % DEPTH);
    endfunction

    // Apply one operation to the model and return the result it should give.
    function automatic rbd_out_t deque_apply(input rbd_in_t req);
        rbd_out_t r;
        r = '0;
        r.status = STAT_DONE;
        case (req.op)
            OP_PUSH_FRONT: begin
                if (used == CW'(DEPTH)) begin
                    r.status = STAT_FULL;
                end else begin
                    head_slot = slot_at(DEPTH - 1);
                    ring[head_slot] = req.value;
                    used = used + 1'b1;
                end
            end
            OP_PUSH_BACK: begin
                if (used == CW'(DEPTH)) begin
                    r.status = STAT_FULL;
                end else begin
                    ring[slot_at(int'(used))] = req.value;
                    used = used + 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (used == '0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    r.data = ring[head_slot];
                    head_slot = slot_at(1);
                    used = used - 1'b1;
                end
            end
            OP_POP_BACK: begin
                if (used == '0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    r.data = ring[slot_at(int'(used) - 1)];
                    used = used - 1'b1;
                end
            end
            OP_CLEAR: begin
                head_slot = '0;
                used = '0;
            end
            default: begin
            end
        endcase
        r.now_empty  = (used == '0);
        r.now_full   = (used == CW'(DEPTH));
        r.fill_count = FILL_W'(used);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [DATA_W-1:0] want_v,
                               input logic [DATA_W-1:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    initial begin
        mismatches = 0;
        pending = 0;
    end

    always @(posedge aclk) begin
        rbd_out_t want;
        if (!aresetn) begin
            head_slot = '0;
            used = '0;
            predicted_results.delete();
        end else begin
            if (s_valid && s_ready) begin
                predicted_results.push_back(deque_apply(s_item));
            end
            if (m_valid && m_ready) begin
                if (predicted_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_item);
                    mismatches++;
                end else begin
                    want = predicted_results.pop_front();
                    check_field("data", want.data, m_item.data);
                    check_field("status", DATA_W'(want.status), DATA_W'(m_item.status));
                    check_field("now_empty", DATA_W'(want.now_empty),
                                DATA_W'(m_item.now_empty));
                    check_field("now_full", DATA_W'(want.now_full),
                                DATA_W'(m_item.now_full));
                    check_field("fill_count", DATA_W'(want.fill_count),
                                DATA_W'(m_item.fill_count));
                end
            end
        end
        pending = predicted_results.size();
    end

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives operation transactions into the ring buffer deque and gives the
// verdict. A directed opening covers empty and full rejects, wrap of the
// head, extremes of the data word, clear and an unused op code; random
// episodes then bias toward filling or draining so both ends are hit often.
// ----------------------------------------------------------------------------
module tb_top;
    import rbd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 924;
    localparam int TAIL_ITEMS   = 150;
    localparam int PAUSE_AT     = 450;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    rbd_in_t  s_item;
    logic     m_valid;
    logic     m_ready;
    rbd_out_t m_item;

    int mismatches;
    int pending;

    // Set for the closing stretch: both sides stop idling.
    bit quiet_tail;
    // Odds (1 in n) of an idle burst after each transaction; 0 means none.
    int gap_odds;

    ring_buffer_deque dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    deque_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Offer one transaction at the falling edge and hold it until accepted.
    // Valid is left high so a following call keeps the channel busy.
    task automatic send_op(input logic [2:0] op, input logic [DATA_W-1:0] value);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_item.op <= op;
        s_item.value <= value;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid for a random idle burst, unless idling is off.
    task automatic sender_idle();
        if (!quiet_tail && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            s_item.value <= $urandom;
            repeat ($urandom_range(0, 10)) @(negedge aclk);
        end
    endtask

    // Half the time an extreme, zero or all ones; otherwise a random word.
    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Pick one op for a random episode; push_pct sets the bias toward filling.
    function automatic logic [2:0] pick_op(input int push_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 2) return OP_CLEAR;
        if (roll < 4) return 3'($urandom_range(5, 7));
        if ($urandom_range(0, 99) < push_pct)
            return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
    endfunction

    // Stimulus and verdict.
    initial begin
        int push_pct;
        int run_left;
        aresetn  = 1'b0;
        s_valid  = 1'b0;
        s_item   = '0;
        quiet_tail = 1'b0;
        gap_odds = 4;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: pops on an empty store first.
        send_op(OP_POP_FRONT, 32'h1234_5678);
        sender_idle();
        send_op(OP_POP_BACK, '1);
        // Push front from head zero wraps the head to the top slot.
        send_op(OP_PUSH_FRONT, 32'h8000_0000);
        send_op(OP_PUSH_BACK, 32'h7fff_ffff);
        send_op(3'd5, $urandom);
        sender_idle();
        send_op(OP_POP_FRONT, '0);
        send_op(OP_POP_BACK, '0);
        // Fill to the brim from both ends, then try pushing past full.
        for (int i = 0; i < DEPTH; i++) begin
            send_op((i % 2) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_word());
            sender_idle();
        end
        send_op(OP_PUSH_BACK, $urandom);
        send_op(OP_PUSH_FRONT, $urandom);
        // Clear a full store.
        send_op(OP_CLEAR, $urandom);

        // Random episodes: each picks a bias and an idling rate.
        run_left = 0;
        push_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (run_left == 0) begin
                run_left = $urandom_range(10, 40);
                case ($urandom_range(0, 2))
                    0: push_pct = 80;
                    1: push_pct = 20;
                    default: push_pct = 50;
                endcase
                gap_odds = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(2, 6);
            end
            run_left--;
            if (n == RANDOM_ITEMS - TAIL_ITEMS) quiet_tail = 1'b1;
            // Hold off once until every outstanding result has come back.
            if (n == PAUSE_AT) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                wait (pending == 0);
                repeat (20) @(negedge aclk);
            end
            send_op(pick_op(push_pct), pick_word());
            sender_idle();
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pending == 0);
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Result side: random stalls, one long hold-off to back the block up, and
    // a steady ready in the closing stretch.
    initial begin
        int rx_cycle;
        bit long_hold_done;
        rx_cycle = 0;
        long_hold_done = 1'b0;
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (quiet_tail) begin
                m_ready <= 1'b1;
            end else if (!long_hold_done && rx_cycle >= 400) begin
                // Stall long enough that the sender sees s_ready held low.
                m_ready <= 1'b0;
                repeat (150) @(negedge aclk);
                long_hold_done = 1'b1;
            end else if ($urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 10)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
            rx_cycle++;
        end
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #500000;
        $display("FAIL");
        $finish;
    end

endmodule
